// File: hw/rtl/htwa_pkg.sv
// Shared types and codes for the hit time window assigner.
package htwa_pkg;

	localparam int CFG_IDX_W = 1;

	localparam logic [1:0] CMD_START = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_HIT   = 2'd2;

	localparam logic [1:0] STREAM_UP    = 2'd0;
	localparam logic [1:0] STREAM_DOWN  = 2'd1;
	localparam logic [1:0] STREAM_MIXED = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_WIN_START_OFFSET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_WIN_END_OFFSET   = 1'b1;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [31:0] time_value;
		logic [1:0]         window_stream;
		logic [5:0]         hit_plane;
		logic [5:0]         trigger_window;
	} in_item_t;

	typedef struct packed {
		logic       assigned;
		logic [5:0] window_index;
		logic       fallback_used;
		logic       was_unmixed;
	} out_item_t;

	typedef struct packed {
		logic signed [23:0] win_start_offset;
		logic signed [23:0] win_end_offset;
	} cfg_regs_t;

endpackage

// File: hw/rtl/htwa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module htwa_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: hw/rtl/htwa_scan.sv
// Window table memory and the two-pass scan sequencer.
module htwa_scan #(
	parameter int MAX_WINDOWS         = 64,
	parameter int UPSTREAM_LAST_PLANE = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  htwa_pkg::in_item_t   request,
	input  htwa_pkg::cfg_regs_t  cfg,
	output logic                 result_valid,
	output htwa_pkg::out_item_t  result
);

	import htwa_pkg::*;

	localparam int AW = $clog2(MAX_WINDOWS);
	localparam int CW = $clog2(MAX_WINDOWS + 1);
	localparam int XW = (CW > 6) ? CW : 6;
	localparam int DW = 34;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PASS1,
		ST_PASS2
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [5:0]         trig_q;
	logic [CW-1:0]      idx_q;
	logic signed [31:0] hit_time_q;
	logic [1:0]         hit_stream_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic               result_valid_q;
	out_item_t          result_q;

	logic               accept;
	logic               more;
	logic               match;
	logic               issue;
	logic               fit;
	logic [DW-1:0]      rd_data;
	logic [31:0]        rd_start;
	logic [1:0]         rd_stream;
	logic signed [33:0] start_x;
	logic signed [33:0] lo_x;
	logic signed [33:0] hi_x;
	logic signed [33:0] time_x;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [DW-1:0]      ram_wdata;
	logic [XW-1:0]      trig_x;
	logic [XW-1:0]      count_x;
	logic               not_full;

	always_comb begin
		accept    = start && (state_q == ST_IDLE);
		more      = idx_q < count_q;
		not_full  = count_q < CW'(MAX_WINDOWS);
		trig_x    = XW'(trig_q);
		count_x   = XW'(count_q);
		rd_start  = rd_data[33:2];
		rd_stream = rd_data[1:0];
		// Bounds at 34 bits cannot overflow
		start_x   = {{2{rd_start[31]}}, rd_start};
		lo_x      = start_x + {{10{cfg.win_start_offset[23]}}, cfg.win_start_offset};
		hi_x      = start_x + {{10{cfg.win_end_offset[23]}}, cfg.win_end_offset};
		time_x    = {{2{hit_time_q[31]}}, hit_time_q};
		fit       = (time_x > lo_x) && (time_x <= hi_x);
		match     = rd_vld_s1 && fit &&
			((state_q == ST_PASS2) ||
			 ((state_q == ST_PASS1) && (rd_stream == hit_stream_q)));
		issue     = (state_q != ST_IDLE) && more && !match;

		ram_we    = 1'b0;
		ram_waddr = count_q[AW-1:0];
		ram_wdata = {request.time_value, request.window_stream};
		if (accept && (request.cmd == CMD_LOAD) && not_full) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_PASS2) && match) begin
			// Mark the fallback window mixed
			ram_we    = 1'b1;
			ram_waddr = rd_idx_s1;
			ram_wdata = {rd_start, STREAM_MIXED};
		end
	end

	htwa_ram #(
		.WIDTH(DW),
		.DEPTH(MAX_WINDOWS)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			count_q        <= '0;
			trig_q         <= '0;
			idx_q          <= '0;
			hit_time_q     <= '0;
			hit_stream_q   <= STREAM_UP;
			rd_vld_s1      <= 1'b0;
			rd_idx_s1      <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			result_valid_q <= 1'b0;
			rd_vld_s1      <= issue;
			rd_idx_s1      <= idx_q[AW-1:0];
			if (issue) begin
				idx_q <= idx_q + CW'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (request.cmd)
							CMD_START: begin
								trig_q  <= request.trigger_window;
								count_q <= '0;
							end
							CMD_LOAD: begin
								if (not_full) begin
									count_q <= count_q + CW'(1);
								end
							end
							CMD_HIT: begin
								hit_time_q   <= request.time_value;
								hit_stream_q <= (request.hit_plane <= 6'(UPSTREAM_LAST_PLANE)) ?
									STREAM_UP : STREAM_DOWN;
								// Skip pass one when the trigger lies past the list
								if (trig_x < count_x) begin
									idx_q   <= CW'(trig_x);
									state_q <= ST_PASS1;
								end else begin
									idx_q   <= '0;
									state_q <= ST_PASS2;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_PASS1: begin
					if (match) begin
						result_valid_q          <= 1'b1;
						result_q.assigned       <= 1'b1;
						result_q.window_index   <= 6'(rd_idx_s1);
						result_q.fallback_used  <= 1'b0;
						result_q.was_unmixed    <= 1'b0;
						state_q                 <= ST_IDLE;
					end else if (!more && !rd_vld_s1) begin
						idx_q   <= '0;
						state_q <= ST_PASS2;
					end
				end
				ST_PASS2: begin
					if (match) begin
						result_valid_q          <= 1'b1;
						result_q.assigned       <= 1'b1;
						result_q.window_index   <= 6'(rd_idx_s1);
						result_q.fallback_used  <= 1'b1;
						result_q.was_unmixed    <= (rd_stream != STREAM_MIXED);
						state_q                 <= ST_IDLE;
					end else if (!more && !rd_vld_s1) begin
						result_valid_q <= 1'b1;
						result_q       <= '0;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: hw/rtl/hit_time_window_assigner.sv
// Hit time window assigner: start, load and hit items in, one result per hit out.
//
// A start item and a load item leave busy low. A hit item
// raises busy while the window table is scanned, one window per cycle through the
// single read port of the table memory: pass one runs from the trigger window to
// the end of the list, pass two (only if pass one fails) from window 0. The result
// shows on result for exactly one cycle with result_valid high and must be taken
// then; busy is low in that cycle, so the next item may already be started. Write
// the offset registers only while busy is low.
module hit_time_window_assigner #(
	parameter int MAX_WINDOWS         = 64,
	parameter int UPSTREAM_LAST_PLANE = 22
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  htwa_pkg::in_item_t                request,
	output logic                              result_valid,
	output htwa_pkg::out_item_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [htwa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [23:0]                       cfg_data
);

	import htwa_pkg::*;

	cfg_regs_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIN_START_OFFSET: cfg_q.win_start_offset <= cfg_data;
				REG_WIN_END_OFFSET:   cfg_q.win_end_offset   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	htwa_scan #(
		.MAX_WINDOWS        (MAX_WINDOWS),
		.UPSTREAM_LAST_PLANE(UPSTREAM_LAST_PLANE)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.cfg         (cfg_q),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// File: bench/hit_time_window_assigner_tb.sv
// Testbench for the hit time window assigner: random events checked against an inline predictor.
`timescale 1ns / 100ps

module hit_time_window_assigner_tb;
	import htwa_pkg::*;

	localparam int MAX_WINDOWS         = 64;
	localparam int UPSTREAM_LAST_PLANE = 22;
	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int ITEM_TARGET         = 1450;
	localparam int NUM_PHASES          = 7;
	localparam int CFG_GUARD           = 8;
	localparam int LINGER              = 2 * MAX_WINDOWS + 16;
	localparam int QUIET_LIMIT         = 4000;
	localparam longint T_MAX           = 2147483647;
	localparam longint T_MIN           = -T_MAX - 1;

	typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t             kind;
		in_item_t               item;
		logic [CFG_IDX_W-1:0]   reg_idx;
		logic [23:0]            reg_val;
		int                     gap;
	} plan_step_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	in_item_t             request = '0;
	logic                 result_valid;
	out_item_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [23:0]          cfg_data = '0;

	hit_time_window_assigner uut (
		.clk, .arst_n, .start, .busy, .request, .result_valid, .result,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	// predictor state
	logic signed [31:0] win_start_tab [MAX_WINDOWS];
	logic [1:0]         win_stream_tab [MAX_WINDOWS];
	int                 win_count = 0;
	int                 trig_idx = 0;
	longint             lo_offset = 0;
	longint             hi_offset = 0;
	out_item_t          pending_assignments [$];

	// stimulus plan and driver state
	plan_step_t plan [$];
	plan_step_t cur;
	bit         have_cur = 1'b0;
	int         wait_cnt = 0;
	bit         burst = 1'b0;
	int         items_queued = 0;
	int         plan_lo = 0;
	int         plan_hi = 0;
	int         mismatch_count = 0;
	int         quiet_cycles = 0;

	initial forever #5 clk = ~clk;

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	function automatic bit window_fits(int i, longint t);
		longint lo;
		longint hi;
		lo = longint'(win_start_tab[i]) + lo_offset;
		hi = longint'(win_start_tab[i]) + hi_offset;
		return (lo < t) && (t <= hi);
	endfunction

	function automatic void predict_assignment(in_item_t it);
		out_item_t  res;
		logic [1:0] hs;
		longint     t;
		int         i;
		bit         found;
		res = '0;
		found = 1'b0;
		t = longint'($signed(it.time_value));
		case (it.cmd)
		CMD_START: begin
			trig_idx = it.trigger_window;
			win_count = 0;
		end
		CMD_LOAD: begin
			// drop loads once the table is full
			if (win_count < MAX_WINDOWS) begin
				win_start_tab[win_count] = it.time_value;
				win_stream_tab[win_count] = it.window_stream;
				win_count++;
			end
		end
		CMD_HIT: begin
			hs = (it.hit_plane <= UPSTREAM_LAST_PLANE) ? STREAM_UP : STREAM_DOWN;
			for (i = trig_idx; !found && i < win_count; i++) begin
				if (win_stream_tab[i] == hs && window_fits(i, t)) begin
					found = 1'b1;
					res.window_index = i[5:0];
				end
			end
			// any-stream pass marks the taking window mixed
			for (i = 0; !found && i < win_count; i++) begin
				if (window_fits(i, t)) begin
					found = 1'b1;
					res.window_index = i[5:0];
					res.fallback_used = 1'b1;
					res.was_unmixed = (win_stream_tab[i] != STREAM_MIXED);
					win_stream_tab[i] = STREAM_MIXED;
				end
			end
			res.assigned = found;
			pending_assignments = {pending_assignments, res};
		end
		default: ;
		endcase
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		it.cmd = 2'($urandom_range(0, 3));
		it.time_value = $urandom;
		it.window_stream = 2'($urandom_range(0, 3));
		it.hit_plane = 6'($urandom_range(0, 63));
		it.trigger_window = 6'($urandom_range(0, 63));
		return it;
	endfunction

	function automatic in_item_t make_item(logic [1:0] cmd, longint t, logic [1:0] stream,
			int plane, int trig);
		in_item_t it;
		it = random_item();
		it.cmd = cmd;
		it.time_value = t[31:0];
		it.window_stream = stream;
		it.hit_plane = plane[5:0];
		it.trigger_window = trig[5:0];
		return it;
	endfunction

	task automatic queue_item(in_item_t it);
		plan_step_t s;
		s.kind = STEP_ITEM;
		s.item = it;
		s.reg_idx = '0;
		s.reg_val = '0;
		s.gap = burst ? 0 : $urandom_range(0, 10);
		plan = {plan, s};
		if (it.cmd != CMD_UNUSED)
			items_queued++;
	endtask

	task automatic queue_ctrl(step_kind_t kind, logic [CFG_IDX_W-1:0] idx, int val);
		plan_step_t s;
		s.kind = kind;
		s.item = '0;
		s.reg_idx = idx;
		s.reg_val = val[23:0];
		s.gap = (kind == STEP_CFG) ? CFG_GUARD : $urandom_range(0, 10);
		plan = {plan, s};
		if (kind == STEP_CFG && idx == REG_WIN_START_OFFSET)
			plan_lo = val;
		else if (kind == STEP_CFG)
			plan_hi = val;
	endtask

	task automatic queue_offsets(int lo, int hi);
		if ($urandom_range(0, 1)) begin
			queue_ctrl(STEP_CFG, REG_WIN_START_OFFSET, lo);
			queue_ctrl(STEP_CFG, REG_WIN_END_OFFSET, hi);
		end else begin
			queue_ctrl(STEP_CFG, REG_WIN_END_OFFSET, hi);
			queue_ctrl(STEP_CFG, REG_WIN_START_OFFSET, lo);
		end
	endtask

	// One event: start, a list of windows, then hits aimed mostly at the windows.
	task automatic queue_event();
		in_item_t           it;
		logic signed [31:0] starts [MAX_WINDOWS];
		logic signed [31:0] base;
		int                 nwin;
		int                 nheld;
		int                 nhits;
		int                 span;
		int                 spacing;
		int                 w;
		int                 k;
		longint             tt;
		nwin = ($urandom_range(0, 14) == 0) ? $urandom_range(60, 70) : $urandom_range(0, 8);
		nheld = (nwin < MAX_WINDOWS) ? nwin : MAX_WINDOWS;
		burst = ($urandom_range(0, 3) == 0);
		it = random_item();
		it.cmd = CMD_START;
		if ($urandom_range(0, 3) != 0)
			it.trigger_window = 6'($urandom_range(0, (nwin < 63) ? nwin : 63));
		queue_item(it);

		span = plan_hi - plan_lo;
		if (span < 1)
			span = 64;
		spacing = $urandom_range(0, 2 * span);
		case ($urandom_range(0, 5))
		0: base = 32'h7fff_ffff - $urandom_range(0, 4096);
		1: base = 32'h8000_0000 + $urandom_range(0, 4096);
		2: base = $urandom_range(0, 10000);
		default: base = $urandom;
		endcase
		for (k = 0; k < nwin; k++) begin
			it = random_item();
			it.cmd = CMD_LOAD;
			it.time_value = base + k * spacing + $urandom_range(0, 7);
			if (k < MAX_WINDOWS)
				starts[k] = it.time_value;
			queue_item(it);
		end

		nhits = $urandom_range(1, 12);
		for (k = 0; k < nhits; k++) begin
			it = random_item();
			it.cmd = CMD_HIT;
			if (nheld > 0 && $urandom_range(0, 4) != 0) begin
				w = $urandom_range(0, nheld - 1);
				case ($urandom_range(0, 7))
				0: tt = longint'(starts[w]) + plan_lo;
				1: tt = longint'(starts[w]) + plan_lo + 1;
				2: tt = longint'(starts[w]) + plan_hi;
				3: tt = longint'(starts[w]) + plan_hi + 1;
				default: tt = longint'(starts[w]) + plan_lo + int'($urandom_range(0, span + 1));
				endcase
				if (tt > T_MAX)
					tt = T_MAX;
				if (tt < T_MIN)
					tt = T_MIN;
				it.time_value = tt[31:0];
			end
			queue_item(it);
			if ($urandom_range(0, 19) == 0) begin
				it = random_item();
				it.cmd = CMD_UNUSED;
				queue_item(it);
			end
			// stray load in the middle of the hits
			if ($urandom_range(0, 29) == 0) begin
				it = random_item();
				it.cmd = CMD_LOAD;
				queue_item(it);
			end
		end
		if ($urandom_range(0, 9) == 0)
			queue_ctrl(STEP_DRAIN, '0, 0);
	endtask

	initial begin : stimulus
		int lo;
		int hi;
		int p;
		queue_offsets(-32, 160);

		// hit before any start, unused command, then one hand-built event
		queue_item(make_item(CMD_HIT, 5, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_UNUSED, 0, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_START, 0, STREAM_UP, 0, 1));
		queue_item(make_item(CMD_LOAD, 1000, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_LOAD, 1000, STREAM_DOWN, 0, 0));
		queue_item(make_item(CMD_LOAD, 2000, 2'd3, 0, 0));
		queue_item(make_item(CMD_LOAD, T_MIN, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_LOAD, T_MAX, STREAM_DOWN, 0, 0));
		queue_item(make_item(CMD_HIT, 1001, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_HIT, 1160, STREAM_UP, UPSTREAM_LAST_PLANE, 0));
		queue_item(make_item(CMD_HIT, 968, STREAM_UP, UPSTREAM_LAST_PLANE + 1, 0));
		queue_item(make_item(CMD_HIT, 1100, STREAM_UP, 63, 0));
		queue_item(make_item(CMD_HIT, 2001, STREAM_UP, 40, 0));
		queue_item(make_item(CMD_HIT, T_MIN, STREAM_UP, 5, 0));
		queue_item(make_item(CMD_HIT, T_MAX, STREAM_UP, 30, 0));
		// trigger past the loaded windows
		queue_item(make_item(CMD_START, 0, STREAM_UP, 0, 63));
		queue_item(make_item(CMD_LOAD, 0, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_HIT, 10, STREAM_UP, 0, 0));
		queue_item(make_item(CMD_LOAD, 0, STREAM_MIXED, 0, 0));
		queue_item(make_item(CMD_HIT, 5, STREAM_UP, 63, 0));
		queue_ctrl(STEP_DRAIN, '0, 0);

		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
			0: begin lo = -32; hi = 160; end
			1: begin lo = -8388608; hi = 8388607; end
			2: begin lo = 8388607; hi = -8388608; end
			3: begin lo = 0; hi = 0; end
			4: begin lo = -1000; hi = 50000; end
			5: begin lo = 100; hi = 400; end
			default: begin
				lo = $urandom_range(0, 4000) - 2000;
				hi = lo + $urandom_range(0, 3000);
			end
			endcase
			if (p != 0)
				queue_offsets(lo, hi);
			while (items_queued < 20 + (p + 1) * (ITEM_TARGET - 20) / NUM_PHASES)
				queue_event();
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (plan.size() != 0 || have_cur || start || cfg_valid ||
				pending_assignments.size() != 0)
			@(posedge clk);
		repeat (LINGER) @(posedge clk);
		if (pending_assignments.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_assignments.size()));
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin : drive
		logic start_n;
		logic cfg_n;
		bit   drained;
		if (arst_n) begin
			start_n = start;
			cfg_n = cfg_valid;
			if (start && !busy) begin
				predict_assignment(request);
				start_n = 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_WIN_START_OFFSET)
					lo_offset = longint'($signed(cfg_data));
				else
					hi_offset = longint'($signed(cfg_data));
				cfg_n = 1'b0;
			end
			if (!start_n && !cfg_n) begin
				if (!have_cur && plan.size() != 0) begin
					cur = plan.pop_front();
					have_cur = 1'b1;
					wait_cnt = cur.gap;
				end
				if (have_cur) begin
					drained = (pending_assignments.size() == 0) && !busy;
					// register writes and pauses hold until every result is in
					if (cur.kind == STEP_ITEM || drained) begin
						if (wait_cnt > 0) begin
							wait_cnt--;
						end else begin
							case (cur.kind)
							STEP_ITEM: begin
								request <= cur.item;
								start_n = 1'b1;
							end
							STEP_CFG: begin
								cfg_index <= cur.reg_idx;
								cfg_data <= cur.reg_val;
								cfg_n = 1'b1;
							end
							default: ;
							endcase
							have_cur = 1'b0;
						end
					end
				end
			end
			start <= start_n;
			cfg_valid <= cfg_n;
		end
	end

	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n && result_valid) begin
			if (pending_assignments.size() == 0) begin
				report_mismatch($sformatf("result %h with nothing pending", result));
			end else begin
				want = pending_assignments.pop_front();
				if (result.assigned !== want.assigned)
					report_mismatch($sformatf("assigned %b, want %b",
						result.assigned, want.assigned));
				if (result.window_index !== want.window_index)
					report_mismatch($sformatf("window_index %0d, want %0d",
						result.window_index, want.window_index));
				if (result.fallback_used !== want.fallback_used)
					report_mismatch($sformatf("fallback_used %b, want %b",
						result.fallback_used, want.fallback_used));
				if (result.was_unmixed !== want.was_unmixed)
					report_mismatch($sformatf("was_unmixed %b, want %b",
						result.was_unmixed, want.was_unmixed));
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// File: files.f
hw/rtl/htwa_pkg.sv
hw/rtl/htwa_ram.sv
hw/rtl/htwa_scan.sv
hw/rtl/hit_time_window_assigner.sv
bench/hit_time_window_assigner_tb.sv
